@@ hdl/ipaf_pkg.sv @@
// ----------------------------------------------------------------------------
// ipaf_pkg - shared types and constants of the ipv4 port allow filter
// Frame offsets, protocol codes, verdict reason codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package ipaf_pkg;

   localparam int unsigned COUNT_W = 7;

   localparam logic [15:0] ETHERTYPE_ARP  = 16'h0806;
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [3:0]  IP_VERSION_4   = 4'd4;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;

   // byte offsets within the frame
   localparam logic [COUNT_W-1:0] OFS_ETYPE_HI = 7'd12;
   localparam logic [COUNT_W-1:0] OFS_ETYPE_LO = 7'd13;
   localparam logic [COUNT_W-1:0] OFS_IP_HDR   = 7'd14;
   localparam logic [COUNT_W-1:0] OFS_PROTO    = 7'd23;
   localparam logic [COUNT_W-1:0] OFS_SRC_LO   = 7'd26;
   localparam logic [COUNT_W-1:0] OFS_SRC_HI   = 7'd29;
   localparam logic [COUNT_W-1:0] OFS_DST_LO   = 7'd30;
   localparam logic [COUNT_W-1:0] OFS_DST_HI   = 7'd33;
   localparam logic [COUNT_W-1:0] COUNT_MAX    = 7'd127;

   localparam logic [COUNT_W:0] MIN_FRAME_LEN = 8'd34;
   localparam logic [COUNT_W:0] TRANSPORT_LEN = 8'd8;

   typedef enum logic [2:0] {
      RSN_SHORT       = 3'd0,
      RSN_ARP         = 3'd1,
      RSN_MATCH       = 3'd2,
      RSN_NOT_IPV4    = 3'd3,
      RSN_BAD_VERSION = 3'd4,
      RSN_SHORT_XPORT = 3'd5,
      RSN_BAD_PROTO   = 3'd6,
      RSN_NO_MATCH    = 3'd7
   } reason_type;

   typedef enum logic {
      CSR_ALLOWED_ADDR = 1'b0,
      CSR_ALLOWED_PORT = 1'b1
   } csr_index_type;

endpackage : ipaf_pkg

`default_nettype wire

@@ hdl/ipv4_port_allow_filter_core.sv @@
// ----------------------------------------------------------------------------
// ipv4_port_allow_filter_core - per-frame pass/drop filter for ipv4 tcp/udp
// Parses an ethernet frame byte by byte and returns one verdict per frame.
// ----------------------------------------------------------------------------
// The core takes one frame byte per req transaction, the last byte of a frame
// flagged by req_last_byte, and sustains one byte per clock cycle while
// req_ready is high. Each byte updates the header captures and the byte
// counter in the cycle it is taken; the final byte of a frame produces a
// single rsp transaction carrying a verdict (1 pass, 0 drop) and a reason
// code, available in the cycle after that byte is taken. The result sits
// in a one-deep output register: req_ready drops only while a verdict is
// waiting and rsp_ready is low. Frames under 34 bytes and arp frames pass;
// non-ipv4, wrong version, frames too short for a transport header and non
// tcp/udp protocols are dropped; the rest pass only when source address and
// port, or destination address and port, equal the allowed pair set through
// the csr port (index 0 address, index 1 port, reset 0 and 22). The byte
// counter saturates at 127, which is past every offset the parser looks at.
`default_nettype none

module ipv4_port_allow_filter_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // byte stream in
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_frame_byte,
   input  wire logic        req_last_byte,
   // verdict out
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_verdict,
   output logic [2:0]       rsp_reason,
   // register writes
   input  wire logic        csr_we,
   input  wire ipaf_pkg::csr_index_type csr_index,
   input  wire logic [31:0] csr_wdata
);

   import ipaf_pkg::*;

   // configuration
   logic [31:0] allowed_addr_ff;
   logic [15:0] allowed_port_ff;

   // per-frame captures
   logic [COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic [15:0]        ether_type_ff, ether_type_in;
   logic [3:0]         ip_version_ff, ip_version_in;
   logic [3:0]         header_words_ff, header_words_in;
   logic [7:0]         proto_code_ff, proto_code_in;
   logic [31:0]        source_addr_ff, source_addr_in;
   logic [31:0]        dest_addr_ff, dest_addr_in;
   logic [15:0]        source_port_ff, source_port_in;
   logic [15:0]        dest_port_ff, dest_port_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       verdict_ff, verdict_in;
   reason_type reason_ff, reason_in;

   // captured view including the current byte
   logic [15:0]        cur_ether_type;
   logic [3:0]         cur_version;
   logic [3:0]         cur_words;
   logic [7:0]         cur_proto;
   logic [31:0]        cur_src_addr;
   logic [31:0]        cur_dst_addr;
   logic [15:0]        cur_src_port;
   logic [15:0]        cur_dst_port;
   logic [COUNT_W-1:0] port_ofs;
   logic [COUNT_W:0]   frame_len;
   logic [COUNT_W:0]   xport_min_len;
   logic               accept;
   logic               pos;
   logic               pair_match;

   assign accept    = req_valid && req_ready;
   // the output register is free or being emptied this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;

   // ---------------------------------------------------------------- csr
   always_ff @(posedge clock) begin
      if (reset) begin
         allowed_addr_ff <= '0;
         allowed_port_ff <= 16'd22;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ALLOWED_ADDR: allowed_addr_ff <= csr_wdata;
            CSR_ALLOWED_PORT: allowed_port_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- parse
   always_comb begin
      // header length from this byte when it is the first ip header byte,
      // so a zero length places the ports right on top of it
      cur_version = ip_version_ff;
      cur_words   = header_words_ff;
      if (byte_count_ff == OFS_IP_HDR) begin
         cur_version = req_frame_byte[7:4];
         cur_words   = req_frame_byte[3:0];
      end

      cur_ether_type = ether_type_ff;
      if (byte_count_ff == OFS_ETYPE_HI || byte_count_ff == OFS_ETYPE_LO) begin
         cur_ether_type = {ether_type_ff[7:0], req_frame_byte};
      end

      cur_proto = proto_code_ff;
      if (byte_count_ff == OFS_PROTO) begin
         cur_proto = req_frame_byte;
      end

      cur_src_addr = source_addr_ff;
      if (byte_count_ff >= OFS_SRC_LO && byte_count_ff <= OFS_SRC_HI) begin
         cur_src_addr = {source_addr_ff[23:0], req_frame_byte};
      end

      cur_dst_addr = dest_addr_ff;
      if (byte_count_ff >= OFS_DST_LO && byte_count_ff <= OFS_DST_HI) begin
         cur_dst_addr = {dest_addr_ff[23:0], req_frame_byte};
      end

      // transport header start, at most 74
      port_ofs = OFS_IP_HDR + {1'b0, cur_words, 2'b00};

      cur_src_port = source_port_ff;
      if (byte_count_ff == port_ofs || byte_count_ff == port_ofs + 7'd1) begin
         cur_src_port = {source_port_ff[7:0], req_frame_byte};
      end

      cur_dst_port = dest_port_ff;
      if (byte_count_ff == port_ofs + 7'd2 || byte_count_ff == port_ofs + 7'd3) begin
         cur_dst_port = {dest_port_ff[7:0], req_frame_byte};
      end
   end

   // ---------------------------------------------------------------- decide
   assign frame_len     = {1'b0, byte_count_ff} + 8'd1;
   assign xport_min_len = {1'b0, port_ofs} + TRANSPORT_LEN;
   assign pair_match    = (cur_src_addr == allowed_addr_ff && cur_src_port == allowed_port_ff)
                       || (cur_dst_addr == allowed_addr_ff && cur_dst_port == allowed_port_ff);

   always_comb begin
      verdict_in = 1'b0;
      reason_in  = RSN_NO_MATCH;
      if (frame_len < MIN_FRAME_LEN) begin
         verdict_in = 1'b1;
         reason_in  = RSN_SHORT;
      end else if (cur_ether_type == ETHERTYPE_ARP) begin
         verdict_in = 1'b1;
         reason_in  = RSN_ARP;
      end else if (cur_ether_type != ETHERTYPE_IPV4) begin
         reason_in = RSN_NOT_IPV4;
      end else if (cur_version != IP_VERSION_4) begin
         reason_in = RSN_BAD_VERSION;
      end else if (frame_len < xport_min_len) begin
         reason_in = RSN_SHORT_XPORT;
      end else if (cur_proto != PROTO_TCP && cur_proto != PROTO_UDP) begin
         reason_in = RSN_BAD_PROTO;
      end else if (pair_match) begin
         verdict_in = 1'b1;
         reason_in  = RSN_MATCH;
      end
   end

   // ---------------------------------------------------------------- next state
   assign pos = accept && req_last_byte;

   always_comb begin
      byte_count_in   = byte_count_ff;
      ether_type_in   = ether_type_ff;
      ip_version_in   = ip_version_ff;
      header_words_in = header_words_ff;
      proto_code_in   = proto_code_ff;
      source_addr_in  = source_addr_ff;
      dest_addr_in    = dest_addr_ff;
      source_port_in  = source_port_ff;
      dest_port_in    = dest_port_ff;
      if (pos) begin
         // end of frame: start the next one from scratch
         byte_count_in   = '0;
         ether_type_in   = '0;
         ip_version_in   = '0;
         header_words_in = '0;
         proto_code_in   = '0;
         source_addr_in  = '0;
         dest_addr_in    = '0;
         source_port_in  = '0;
         dest_port_in    = '0;
      end else if (accept) begin
         // saturating count
         if (byte_count_ff != COUNT_MAX) begin
            byte_count_in = byte_count_ff + 7'd1;
         end
         ether_type_in   = cur_ether_type;
         ip_version_in   = cur_version;
         header_words_in = cur_words;
         proto_code_in   = cur_proto;
         source_addr_in  = cur_src_addr;
         dest_addr_in    = cur_dst_addr;
         source_port_in  = cur_src_port;
         dest_port_in    = cur_dst_port;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (pos) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff   <= '0;
         ether_type_ff   <= '0;
         ip_version_ff   <= '0;
         header_words_ff <= '0;
         proto_code_ff   <= '0;
         source_addr_ff  <= '0;
         dest_addr_ff    <= '0;
         source_port_ff  <= '0;
         dest_port_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         byte_count_ff   <= byte_count_in;
         ether_type_ff   <= ether_type_in;
         ip_version_ff   <= ip_version_in;
         header_words_ff <= header_words_in;
         proto_code_ff   <= proto_code_in;
         source_addr_ff  <= source_addr_in;
         dest_addr_ff    <= dest_addr_in;
         source_port_ff  <= source_port_in;
         dest_port_ff    <= dest_port_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // result payload, loaded only with a new verdict
   always_ff @(posedge clock) begin
      if (pos) begin
         verdict_ff <= verdict_in;
         reason_ff  <= reason_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = verdict_ff;
   assign rsp_reason  = reason_ff;

   // ---------------------------------------------------------------- checks
   // a waiting verdict must hold off the byte stream
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("byte taken while a verdict is stalled");

   // every final byte yields a verdict and restarts the counter
   a_last_gives_verdict: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_byte |=> rsp_valid_ff && byte_count_ff == '0)
      else $error("final byte without verdict or counter restart");

   // pass verdicts only come with pass reasons
   a_verdict_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> verdict_ff == (reason_ff == RSN_SHORT || reason_ff == RSN_ARP
                                      || reason_ff == RSN_MATCH))
      else $error("verdict disagrees with reason");

endmodule : ipv4_port_allow_filter_core

`default_nettype wire
